[hw/rtl/rmss_pkg.sv]
// Shared types and constants for the sloped-square ring modulator.
// Holds the configuration index codes, the write-port struct and fixed widths.
// No dependencies.
`default_nettype none

package rmss_pkg;

	localparam int CFG_DATA_W  = 24;
	localparam int PINC_W      = 24;
	localparam int DEPTH_W     = 17;
	localparam int LFO_W       = 17;
	localparam int TERM_W      = 18;
	localparam int GAIN_W      = 18;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [LFO_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [0:0] {
		CFG_PHASE_INCREMENT = 1'b0,
		CFG_MOD_DEPTH       = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                  we;
		cfg_idx_t              index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

`default_nettype wire

[hw/rtl/rmss_front.sv]
// Front end: accepts stereo items, evaluates the sloped-square carrier from the
// phase accumulator and pushes samples plus carrier level into the queue.
// Depends on rmss_pkg.
`default_nettype none

module rmss_front #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int PHASE_WIDTH  = 24
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire rmss_pkg::cfg_wr_t                         cfg,
	input  wire logic                                      in_valid,
	output logic                                           in_ready,
	input  wire logic [2*SAMPLE_WIDTH-1:0]                 in_data,
	output logic                                           push,
	output logic [2*SAMPLE_WIDTH+rmss_pkg::LFO_W-1:0]      push_data,
	input  wire logic                                      q_full
);
	import rmss_pkg::*;

	localparam int PW6 = PHASE_WIDTH + 6;
	localparam logic [63:0] CYCLE = 64'd1 << PHASE_WIDTH;
	localparam logic [63:0] T48   = (48 * CYCLE + 99) / 100;
	localparam logic [63:0] T50   = CYCLE / 2;
	localparam logic [63:0] T98   = (98 * CYCLE + 99) / 100;
	localparam logic [PHASE_WIDTH-1:0] T48_C = T48[PHASE_WIDTH-1:0];
	localparam logic [PHASE_WIDTH-1:0] T50_C = T50[PHASE_WIDTH-1:0];
	localparam logic [PHASE_WIDTH-1:0] T98_C = T98[PHASE_WIDTH-1:0];
	localparam logic [63:0] K25W = 25 * CYCLE;
	localparam logic [63:0] K49W = 49 * CYCLE;
	localparam logic [PW6-1:0] K25 = K25W[PW6-1:0];
	localparam logic [PW6-1:0] K49 = K49W[PW6-1:0];
	localparam logic [PW6-1:0] FIFTY = PW6'(50);

	logic [PINC_W-1:0]      inc_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic [PW6-1:0]         ph50;
	logic [PW6-1:0]         diff;
	logic [PW6+15:0]        ramp;
	logic [LFO_W-1:0]       lfo;

	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	assign push_data = {lfo, in_data};

	always_comb begin
		ph50 = {6'b0, phase_q} * FIFTY;
		diff = '0;
		lfo  = '0;
		priority if (phase_q < T48_C) begin
			lfo = ONE_Q16;
		end else if (phase_q < T50_C) begin
			diff = K25 - ph50;
			lfo  = '0;
		end else if (phase_q < T98_C) begin
			lfo = '0;
		end else begin
			diff = ph50 - K49;
			lfo  = '0;
		end
		ramp = {diff, 16'b0} >> PHASE_WIDTH;
		if (phase_q >= T48_C && phase_q < T50_C || phase_q >= T98_C) begin
			lfo = ramp[LFO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			phase_q <= '0;
		end else begin
			if (cfg.we && cfg.index == CFG_PHASE_INCREMENT) begin
				inc_q <= cfg.wdata[PINC_W-1:0];
			end
			if (push) begin
				phase_q <= phase_q + PHASE_WIDTH'(inc_q);
			end
		end
	end

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> phase_q == $past(phase_q + PHASE_WIDTH'(inc_q)))
		else $error("phase did not advance by the increment");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(phase_q))
		else $error("phase moved without an accepted item");

endmodule

`default_nettype wire

[hw/rtl/rmss_fifo.sv]
// Short queue between front and back ends; register storage with count.
// Depends on rmss_pkg for the queue depth.
`default_nettype none

module rmss_fifo #(
	parameter int WIDTH = 65
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      out_data
);
	import rmss_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = count_q == FULL_CNT;
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign do_pop    = pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |-> !full)
		else $error("push into a full queue");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !push |=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

[hw/rtl/rmss_back.sv]
// Back end: gain from depth and carrier, sample multiply, rounding and saturation.
// Four register stages with per-stage valids; depends on rmss_pkg.
`default_nettype none

module rmss_back #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire rmss_pkg::cfg_wr_t                         cfg,
	input  wire logic                                      in_valid,
	output logic                                           in_ready,
	input  wire logic [2*SAMPLE_WIDTH+rmss_pkg::LFO_W-1:0] in_data,
	output logic                                           out_valid,
	input  wire logic                                      out_ready,
	output logic [2*SAMPLE_WIDTH-1:0]                      out_data
);
	import rmss_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int PROD_W = SW + GAIN_W;
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(32768);
	localparam logic signed [PROD_W-1:0] MAXV = PROD_W'((64'd1 << (SW - 1)) - 64'd1);
	localparam logic signed [PROD_W-1:0] MINV = -MAXV - PROD_W'(1);

	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] d_eff;
	logic [2*DEPTH_W-1:0] dl;
	logic signed [GAIN_W:0] base_w;
	logic signed [GAIN_W:0] gain_w;

	logic                    v1_q, v2_q, v3_q, out_valid_q;
	logic                    adv1, adv2, adv3, adv_out;
	logic signed [SW-1:0]    left_s1, right_s1, left_s2, right_s2;
	logic [TERM_W-1:0]       term_s1;
	logic signed [GAIN_W-1:0] base_s1;
	logic signed [GAIN_W-1:0] gain_s2;
	logic signed [PROD_W-1:0] prodl_s3, prodr_s3;
	logic [2*SW-1:0]         res_q;

	function automatic logic [SW-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		logic signed [PROD_W-1:0] s;
		r = (p + HALF) >>> 16;
		if (r > MAXV) begin
			s = MAXV;
		end else if (r < MINV) begin
			s = MINV;
		end else begin
			s = r;
		end
		return s[SW-1:0];
	endfunction

	assign d_eff  = (depth_q > ONE_Q16) ? ONE_Q16 : depth_q;
	assign dl     = d_eff * in_data[2*SW +: LFO_W];
	assign base_w = $signed({2'b0, ONE_Q16}) - $signed({1'b0, d_eff, 1'b0});
	assign gain_w = $signed({1'b0, term_s1}) + $signed({base_s1[GAIN_W-1], base_s1});

	assign adv_out   = !out_valid_q || out_ready;
	assign adv3      = !v3_q || adv_out;
	assign adv2      = !v2_q || adv3;
	assign adv1      = !v1_q || adv2;
	assign in_ready  = adv1;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == CFG_MOD_DEPTH) begin
				depth_q <= cfg.wdata[DEPTH_W-1:0];
			end
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
			if (adv_out) begin
				out_valid_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			left_s1  <= in_data[SW-1:0];
			right_s1 <= in_data[2*SW-1:SW];
			term_s1  <= dl[TERM_W+14:15];
			base_s1  <= base_w[GAIN_W-1:0];
		end
		if (adv2 && v1_q) begin
			left_s2  <= left_s1;
			right_s2 <= right_s1;
			gain_s2  <= gain_w[GAIN_W-1:0];
		end
		if (adv3 && v2_q) begin
			prodl_s3 <= PROD_W'(left_s2) * PROD_W'(gain_s2);
			prodr_s3 <= PROD_W'(right_s2) * PROD_W'(gain_s2);
		end
		if (adv_out && v3_q) begin
			res_q <= {round_sat(prodr_s3), round_sat(prodl_s3)};
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ring_modulator_sloped_square_unit.sv]
// Stereo ring modulator with a sloped-square carrier: front end, queue, back end.
// Items pass the queue, back-end stages 1-3 and the output register to m_tvalid.
// Throughput: one item per cycle while m_tready is high, via the four-stage back end.
// Reset (arst_n low) clears phase, increment, depth, queue and all stage valids.
// Depends on rmss_pkg, rmss_front, rmss_fifo and rmss_back.
`default_nettype none

module ring_modulator_sloped_square_unit #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int PHASE_WIDTH  = 24,
	localparam int TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire rmss_pkg::cfg_idx_t                   cfg_index,
	input  wire logic [rmss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [TDATA_W-1:0]                   s_tdata,  // left_sample, right_sample
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [TDATA_W-1:0]                        m_tdata   // left_result, right_result
);
	import rmss_pkg::*;

	localparam int Q_W = 2 * SAMPLE_WIDTH + LFO_W;

	cfg_wr_t                  cfg;
	logic                     push;
	logic [Q_W-1:0]           push_data;
	logic                     q_full;
	logic                     q_valid;
	logic                     q_pop;
	logic [Q_W-1:0]           q_data;
	logic [2*SAMPLE_WIDTH-1:0] res_data;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;
	assign m_tdata   = TDATA_W'(res_data);

	rmss_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.PHASE_WIDTH (PHASE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata[2*SAMPLE_WIDTH-1:0]),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	rmss_fifo #(
		.WIDTH(Q_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.out_valid(q_valid),
		.pop      (q_pop),
		.out_data (q_data)
	);

	rmss_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (q_valid),
		.in_ready (q_pop),
		.in_data  (q_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (res_data)
	);

endmodule

`default_nettype wire
